@@ src/trdt_pkg.sv @@
// Shared types and constants for the triangle rasterizer with depth test.
// No dependencies; imported by trdt_front, trdt_back and the top level.
package trdt_pkg;

  typedef logic signed [11:0] coord_t;   // vertex coordinate, delta or offset
  typedef logic signed [17:0] vz_t;      // vertex depth
  typedef logic signed [19:0] depth_t;   // stored depth
  typedef logic [1:0]         op_t;

  localparam op_t OP_CLEAR = 2'd0;
  localparam op_t OP_DRAW  = 2'd1;
  localparam op_t OP_READ  = 2'd2;

  localparam logic [1:0] CFG_FILL_COLOR  = 2'd0;
  localparam logic [1:0] CFG_CLEAR_COLOR = 2'd1;
  localparam logic [1:0] CFG_CLEAR_DEPTH = 2'd2;

  localparam int WEIGHT_ONE = 1000;
  localparam int IN_DATA_W  = 136;
  localparam int OUT_DATA_W = 40;

  typedef struct packed {
    logic [3:0] fill_color;
    logic [3:0] clear_color;
    depth_t     clear_depth;
  } cfg_t;

  // Decoded command passed from front to back.
  typedef struct packed {
    op_t        op;
    logic       rd_ok;
    logic [6:0] rd_col;
    logic [5:0] rd_row;
    logic       box_empty;
    coord_t     lox, loy, hix, hiy;
    coord_t     dx21, dy21, dx32, dy32, dx13, dy13;
    coord_t     ox1, oy1, ox2, oy2, ox3, oy3;
    vz_t        z1, z2, z3;
  } cmd_t;

  typedef struct packed {
    logic [3:0]  color;
    depth_t      depth;
    logic [12:0] count;
    logic        degen;
  } res_t;

endpackage

@@ src/trdt_div.sv @@
// Restoring divider, one quotient bit per cycle.
// Requires num < den * 2**QW. Depends on nothing.
module trdt_div #(
  parameter int NW = 34,
  parameter int DW = 24,
  parameter int QW = 10
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          done,
  output logic [QW-1:0] quo
);
  localparam int SW   = DW + QW;
  localparam int CNTW = $clog2(QW + 1);

  logic [SW-1:0]   rem, dsh;
  logic [CNTW-1:0] left;
  logic            busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      left <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem  <= SW'(num);
        dsh  <= SW'(den) << (QW - 1);
        quo  <= '0;
        left <= CNTW'(QW);
        busy <= 1'b1;
      end else if (busy) begin
        if (rem >= dsh) begin
          rem <= rem - dsh;
          quo <= {quo[QW-2:0], 1'b1};
        end else begin
          quo <= {quo[QW-2:0], 1'b0};
        end
        dsh  <= dsh >> 1;
        left <= left - 1'b1;
        if (left == CNTW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

@@ src/trdt_front.sv @@
// Front end: accepts input words, decodes op, clamps the bounding box and
// forms edge deltas, then queues the command (2 entries). Uses trdt_pkg.
module trdt_front #(
  parameter int SCREEN_WIDTH  = 80,
  parameter int SCREEN_HEIGHT = 60
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  trdt_pkg::op_t                  in_op,
  input  logic [trdt_pkg::IN_DATA_W-1:0] in_data,
  input  logic                           hold,
  input  logic                           cmd_pop,
  output logic                           cmd_valid,
  output trdt_pkg::cmd_t                 cmd
);
  import trdt_pkg::*;

  localparam coord_t XMAX = coord_t'(SCREEN_WIDTH - 1);
  localparam coord_t YMAX = coord_t'(SCREEN_HEIGHT - 1);

  function automatic coord_t sx11(input logic [10:0] v);
    return {v[10], v};
  endfunction

  coord_t x1, y1, x2, y2, x3, y3, minx, maxx, miny, maxy;
  cmd_t   dec;
  cmd_t   q [2];
  logic   wr_ptr, rd_ptr;
  logic [1:0] fill;
  logic   push, pop;

  always_comb begin
    x1 = sx11(in_data[10:0]);
    y1 = sx11(in_data[21:11]);
    x2 = sx11(in_data[50:40]);
    y2 = sx11(in_data[61:51]);
    x3 = sx11(in_data[90:80]);
    y3 = sx11(in_data[101:91]);
    minx = (x1 < x2) ? x1 : x2;
    minx = (x3 < minx) ? x3 : minx;
    maxx = (x1 > x2) ? x1 : x2;
    maxx = (x3 > maxx) ? x3 : maxx;
    miny = (y1 < y2) ? y1 : y2;
    miny = (y3 < miny) ? y3 : miny;
    maxy = (y1 > y2) ? y1 : y2;
    maxy = (y3 > maxy) ? y3 : maxy;

    dec.op     = in_op;
    dec.rd_col = in_data[126:120];
    dec.rd_row = in_data[132:127];
    dec.rd_ok  = (11'(in_data[126:120]) < 11'(SCREEN_WIDTH)) &&
                 (11'(in_data[132:127]) < 11'(SCREEN_HEIGHT));
    dec.lox = (minx < 0) ? '0 : minx;
    dec.loy = (miny < 0) ? '0 : miny;
    dec.hix = (maxx > XMAX) ? XMAX : maxx;
    dec.hiy = (maxy > YMAX) ? YMAX : maxy;
    dec.box_empty = (dec.lox > dec.hix) || (dec.loy > dec.hiy);
    dec.dx21 = x2 - x1;
    dec.dy21 = y2 - y1;
    dec.dx32 = x3 - x2;
    dec.dy32 = y3 - y2;
    dec.dx13 = x1 - x3;
    dec.dy13 = y1 - y3;
    dec.ox1 = dec.lox - x1;
    dec.oy1 = dec.loy - y1;
    dec.ox2 = dec.lox - x2;
    dec.oy2 = dec.loy - y2;
    dec.ox3 = dec.lox - x3;
    dec.oy3 = dec.loy - y3;
    dec.z1 = in_data[39:22];
    dec.z2 = in_data[79:62];
    dec.z3 = in_data[119:102];
  end

  assign in_ready  = (fill != 2'd2) && !hold;
  assign push      = in_valid && in_ready;
  assign cmd_valid = (fill != 2'd0);
  assign pop       = cmd_pop && cmd_valid;
  assign cmd       = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        q[wr_ptr] <= dec;
        wr_ptr    <= ~wr_ptr;
      end
      if (pop) rd_ptr <= ~rd_ptr;
      if (push && !pop) fill <= fill + 2'd1;
      else if (pop && !push) fill <= fill - 2'd1;
    end
  end
endmodule

@@ src/trdt_back.sv @@
// Back end: owns the colour/depth memory and runs clear, read and draw
// commands; scans the box with incremental edge functions. Uses trdt_pkg, trdt_div.
module trdt_back #(
  parameter int SCREEN_WIDTH  = 80,
  parameter int SCREEN_HEIGHT = 60
) (
  input  logic           clk,
  input  logic           rst,
  input  trdt_pkg::cfg_t cfg,
  input  logic           cmd_valid,
  input  trdt_pkg::cmd_t cmd,
  output logic           cmd_pop,
  output logic           init_busy,
  output logic           res_valid,
  input  logic           res_ready,
  output trdt_pkg::res_t res
);
  import trdt_pkg::*;

  localparam int PIX = SCREEN_WIDTH * SCREEN_HEIGHT;
  localparam int AW  = $clog2(PIX);
  localparam int IW  = $clog2(SCREEN_WIDTH);
  localparam int JW  = $clog2(SCREEN_HEIGHT);
  localparam int EW  = 25;
  localparam int SUMW = 29;
  // ceil(2**38 / 1000): |sum| * Z_RECIP >> 38 is exact |sum| / 1000
  localparam logic [28:0] Z_RECIP = 29'd274877907;

  typedef struct packed {
    logic [3:0] color;
    depth_t     depth;
  } pix_t;

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_CLEAR, S_READ, S_RDATA, S_SETUP, S_CHECK, S_EDGE,
    S_WDIV, S_MAC, S_ZABS, S_ZMUL, S_ZDIV, S_WRITE, S_DONE
  } state_t;

  state_t state;
  cmd_t   c;
  logic [AW-1:0] addr, row_addr;
  logic [IW-1:0] i;
  logic [JW-1:0] j;
  logic signed [EW-1:0] e1, e2, e3, r1, r2, r3, tot;
  logic [23:0] total;
  logic [2:0]  step;
  logic [33:0] nw1, nw2, nw3;
  logic        wstart, zneg;
  logic signed [SUMW-1:0] sum;
  logic [27:0] znum;
  logic [55:0] zprod;
  depth_t      newd;
  logic [3:0]  r_color;
  depth_t      r_depth;
  logic [12:0] cnt;
  logic        degen;

  pix_t        mem [PIX];
  pix_t        rdata, wdata;
  logic        we, re;

  // setup multiplier and MAC multiplier
  coord_t ma, mb;
  logic signed [EW-1:0] sprod;
  logic [9:0] mw;
  vz_t        mz;
  logic signed [SUMW-1:0] mprod;

  logic [9:0] w1, w2, w3;
  logic       wdone, wd2, wd3;
  logic [17:0] zq;

  logic covered, last_col, last_row, pass;

  trdt_div #(.NW(34), .DW(24), .QW(10)) u_div_a (
    .clk, .rst, .start(wstart), .num(nw1), .den(total), .done(wdone), .quo(w1));
  trdt_div #(.NW(34), .DW(24), .QW(10)) u_div_b (
    .clk, .rst, .start(wstart), .num(nw2), .den(total), .done(wd2), .quo(w2));
  trdt_div #(.NW(34), .DW(24), .QW(10)) u_div_c (
    .clk, .rst, .start(wstart), .num(nw3), .den(total), .done(wd3), .quo(w3));

  always_comb begin
    case (step)
      3'd0: begin ma = c.dy21; mb = c.dx13; end
      3'd1: begin ma = c.dx21; mb = c.dy13; end
      3'd2: begin ma = c.dx21; mb = c.oy1;  end
      3'd3: begin ma = c.dy21; mb = c.ox1;  end
      3'd4: begin ma = c.dx32; mb = c.oy2;  end
      3'd5: begin ma = c.dy32; mb = c.ox2;  end
      3'd6: begin ma = c.dx13; mb = c.oy3;  end
      default: begin ma = c.dy13; mb = c.ox3; end
    endcase
    sprod = ma * mb;
    case (step)
      3'd0: begin mw = w1; mz = c.z1; end
      3'd1: begin mw = w2; mz = c.z2; end
      default: begin mw = w3; mz = c.z3; end
    endcase
    mprod = $signed({1'b0, mw}) * mz;
  end

  assign zq = zprod[55:38];

  assign covered = (e1 >= 0 && e2 >= 0 && e3 >= 0) || (e1 <= 0 && e2 <= 0 && e3 <= 0);
  assign last_col = (i == c.hix[IW-1:0]);
  assign last_row = (j == c.hiy[JW-1:0]);
  assign pass     = (rdata.depth < newd);

  assign cmd_pop   = (state == S_IDLE) && cmd_valid;
  assign init_busy = (state == S_INIT);
  assign re = (state == S_READ) || (state == S_EDGE);
  assign we = (state == S_INIT) || (state == S_CLEAR) || ((state == S_WRITE) && pass);
  assign wdata = ((state == S_INIT) || (state == S_CLEAR)) ?
                 pix_t'({cfg.clear_color, cfg.clear_depth}) :
                 pix_t'({cfg.fill_color, newd});

  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    if (re) rdata <= mem[addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT;
      addr      <= '0;
      res_valid <= 1'b0;
      wstart    <= 1'b0;
    end else begin
      wstart <= 1'b0;
      if (res_valid && res_ready) res_valid <= 1'b0;
      unique case (state)
        S_INIT, S_CLEAR: begin
          addr <= addr + 1'b1;
          if (addr == AW'(PIX - 1)) state <= (state == S_INIT) ? S_IDLE : S_DONE;
        end
        S_IDLE: begin
          if (cmd_valid) begin
            c       <= cmd;
            r_color <= '0;
            r_depth <= '0;
            cnt     <= '0;
            degen   <= 1'b0;
            step    <= '0;
            case (cmd.op)
              OP_CLEAR: begin
                addr  <= '0;
                state <= S_CLEAR;
              end
              OP_DRAW: state <= S_SETUP;
              OP_READ: begin
                addr  <= AW'(int'(cmd.rd_col) + int'(cmd.rd_row) * SCREEN_WIDTH);
                state <= cmd.rd_ok ? S_READ : S_DONE;
              end
              default: state <= S_DONE;
            endcase
          end
        end
        S_READ: state <= S_RDATA;
        S_RDATA: begin
          r_color <= rdata.color;
          r_depth <= rdata.depth;
          state   <= S_DONE;
        end
        S_SETUP: begin
          case (step)
            3'd0: tot <= sprod;
            3'd1: tot <= tot - sprod;
            3'd2: e1 <= sprod;
            3'd3: e1 <= e1 - sprod;
            3'd4: e2 <= sprod;
            3'd5: e2 <= e2 - sprod;
            3'd6: e3 <= sprod;
            default: e3 <= e3 - sprod;
          endcase
          step <= step + 3'd1;
          if (step == 3'd7) state <= S_CHECK;
        end
        S_CHECK: begin
          total    <= 24'((tot < 0) ? -tot : tot);
          r1 <= e1;
          r2 <= e2;
          r3 <= e3;
          i  <= c.lox[IW-1:0];
          j  <= c.loy[JW-1:0];
          addr     <= AW'(int'(c.lox[IW-1:0]) + int'(c.loy[JW-1:0]) * SCREEN_WIDTH);
          row_addr <= AW'(int'(c.lox[IW-1:0]) + int'(c.loy[JW-1:0]) * SCREEN_WIDTH);
          if (tot == 0) begin
            degen <= 1'b1;
            state <= S_DONE;
          end else if (c.box_empty) begin
            state <= S_DONE;
          end else begin
            state <= S_EDGE;
          end
        end
        S_EDGE, S_WRITE: begin
          if (state == S_WRITE && pass && cnt != 13'h1FFF) cnt <= cnt + 13'd1;
          if (state == S_EDGE && covered) begin
            // sub-area opposite each vertex is the edge value of the far edge
            nw1    <= 34'(24'((e2 < 0) ? -e2 : e2)) * 34'(WEIGHT_ONE);
            nw2    <= 34'(24'((e3 < 0) ? -e3 : e3)) * 34'(WEIGHT_ONE);
            nw3    <= 34'(24'((e1 < 0) ? -e1 : e1)) * 34'(WEIGHT_ONE);
            wstart <= 1'b1;
            state  <= S_WDIV;
          end else if (last_col) begin
            if (last_row) begin
              state <= S_DONE;
            end else begin
              j  <= j + 1'b1;
              i  <= c.lox[IW-1:0];
              e1 <= r1 + EW'(c.dx21);
              e2 <= r2 + EW'(c.dx32);
              e3 <= r3 + EW'(c.dx13);
              r1 <= r1 + EW'(c.dx21);
              r2 <= r2 + EW'(c.dx32);
              r3 <= r3 + EW'(c.dx13);
              addr     <= row_addr + AW'(SCREEN_WIDTH);
              row_addr <= row_addr + AW'(SCREEN_WIDTH);
              state <= S_EDGE;
            end
          end else begin
            i    <= i + 1'b1;
            e1   <= e1 - EW'(c.dy21);
            e2   <= e2 - EW'(c.dy32);
            e3   <= e3 - EW'(c.dy13);
            addr <= addr + 1'b1;
            state <= S_EDGE;
          end
        end
        S_WDIV: begin
          step <= '0;
          if (wdone) state <= S_MAC;
        end
        S_MAC: begin
          sum  <= (step == 3'd0) ? mprod : sum + mprod;
          step <= step + 3'd1;
          if (step == 3'd2) state <= S_ZABS;
        end
        S_ZABS: begin
          znum   <= 28'((sum < 0) ? -sum : sum);
          zneg   <= (sum < 0);
          state  <= S_ZMUL;
        end
        S_ZMUL: begin
          zprod <= 56'(znum) * 56'(Z_RECIP);
          state <= S_ZDIV;
        end
        S_ZDIV: begin
          newd  <= zneg ? -$signed({2'b00, zq}) : $signed({2'b00, zq});
          state <= S_WRITE;
        end
        S_DONE: begin
          if (!res_valid || res_ready) begin
            res.color <= r_color;
            res.depth <= r_depth;
            res.count <= cnt;
            res.degen <= degen;
            res_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_degen_no_count: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.degen |-> res.count == 13'd0)
    else $error("degenerate result carries a pixel count");
  a_scan_in_box: assert property (@(posedge clk) disable iff (rst)
    state == S_EDGE |-> (i <= c.hix[IW-1:0]) && (j <= c.hiy[JW-1:0]))
    else $error("scan position left the bounding box");
  a_write_in_range: assert property (@(posedge clk) disable iff (rst)
    we |-> addr <= AW'(PIX - 1))
    else $error("memory write beyond the screen");
  a_weights_sum: assert property (@(posedge clk) disable iff (rst)
    wdone |-> (11'(w1) + 11'(w2) + 11'(w3)) <= 11'(WEIGHT_ONE))
    else $error("barycentric weights exceed one");
  a_div_lockstep: assert property (@(posedge clk) disable iff (rst)
    (wdone == wd2) && (wdone == wd3))
    else $error("weight dividers out of step");
endmodule

@@ src/triangle_rasterizer_depth_test.sv @@
// Top level of the triangle rasterizer with depth buffer.
// Holds the configuration registers; uses trdt_pkg, trdt_front, trdt_back.
//
// Channel   Dir  Handshake              Content
// s_*       in   s_tvalid / s_tready    one command word (clear, draw, read)
// m_*       out  m_tvalid / m_tready    one result word per command
// cfg_*     in   cfg_valid / cfg_ready  register write: index, data
//
// A clear writes every pixel; a read fetches one pixel; a draw runs
// the setup multiplies, then scans the box, and for each covered pixel
// runs three parallel 10-step weight dividers, 3 MAC steps and a
// reciprocal multiply for the depth division. Reset starts a clearing
// pass with s_tready and cfg_ready low.
// A 2-entry command queue lets new words enter while the back end works;
// a finished result waits in the output register without stalling the queue.
module triangle_rasterizer_depth_test #(
  parameter int SCREEN_WIDTH  = 80,
  parameter int SCREEN_HEIGHT = 60
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // ax, ay, az, bx, by, bz, cx, cy, cz, read_col, read_row, pad
  input  logic [135:0] s_tdata,
  // op
  input  logic [1:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // pixel_color, pixel_depth, pixels_written, pad
  output logic [39:0]  m_tdata,
  // degenerate
  output logic         m_tuser,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [19:0]  cfg_data
);
  import trdt_pkg::*;

  cfg_t cfg;
  cmd_t cmd;
  res_t res;
  logic cmd_valid, cmd_pop, init_busy;

  // registers are writable once the reset clearing pass is done;
  // an unknown index is dropped
  assign cfg_ready = ~init_busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.fill_color  <= 4'd5;
      cfg.clear_color <= 4'd1;
      cfg.clear_depth <= -20'sd99999;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_FILL_COLOR:  cfg.fill_color  <= cfg_data[3:0];
        CFG_CLEAR_COLOR: cfg.clear_color <= cfg_data[3:0];
        CFG_CLEAR_DEPTH: cfg.clear_depth <= cfg_data;
        default: ;
      endcase
    end
  end

  trdt_front #(.SCREEN_WIDTH(SCREEN_WIDTH), .SCREEN_HEIGHT(SCREEN_HEIGHT)) u_front (
    .clk, .rst,
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_op    (s_tuser),
    .in_data  (s_tdata),
    .hold     (init_busy),
    .cmd_pop,
    .cmd_valid,
    .cmd
  );

  trdt_back #(.SCREEN_WIDTH(SCREEN_WIDTH), .SCREEN_HEIGHT(SCREEN_HEIGHT)) u_back (
    .clk, .rst,
    .cfg,
    .cmd_valid,
    .cmd,
    .cmd_pop,
    .init_busy,
    .res_valid (m_tvalid),
    .res_ready (m_tready),
    .res
  );

  assign m_tdata = {3'b000, res.count, res.depth, res.color};
  assign m_tuser = res.degen;
endmodule
